// ===== design/uer_pkg.sv =====
// Package: shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

  // Measurement phase
  typedef enum logic [1:0] {
    PH_GAP  = 2'd0,
    PH_TRIG = 2'd1,
    PH_MEAS = 2'd2
  } phase_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CM_SCALE      = 2'd2;

  // Register reset values
  localparam logic [23:0] GAP_TICKS_RST     = 24'd50000;
  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
  localparam logic [23:0] CM_SCALE_RST      = 24'd285326;

  // Result saturation limits
  localparam logic [19:0] DIST_MAX  = 20'hFFFFF;
  localparam logic [15:0] PULSE_MAX = 16'hFFFF;
  localparam logic [7:0]  TRIG_MAX  = 8'hFF;

  // One tick request
  typedef struct packed {
    logic echo_level;
    logic read_clear;
  } uer_in_t;

  // One tick result
  typedef struct packed {
    logic        trigger_out;
    logic        busy_res;
    logic        object_found;
    logic        fresh;
    logic [19:0] distance_q8;
    logic [15:0] pulse_ticks;
  } uer_out_t;

endpackage

// ===== design/ultrasonic_echo_ranger_core.sv =====
// Top level: echo-pulse timer and distance conversion for an ultrasonic ranger.
`timescale 1ns / 1ps

// Usage:
//   Each request on req_* is one counter tick carrying the sampled echo level
//   and a software read strobe. Every request yields exactly one result on
//   res_*, showing trigger drive, busy, object found, new-value flag, the
//   distance in 1/256 cm and the latched echo pulse length in ticks.
//   Requests land in an input register; when that register advances, the tick
//   update (counters, edge detection, one tick x scale multiply) runs and its
//   output loads the result register.
//   Throughput is one request per cycle: the result register drains while a
//   new request is taken, so req_ready stays high as long as res_ready is.
//   When res_ready is low, the result holds, the input register fills and
//   req_ready drops until the result is taken.
//   Reset (rst, synchronous) clears all state, empties both registers and
//   restores gap_ticks = 50000, trigger_ticks = 10, cm_scale = 285326.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
//   the user must make them with no request in flight; the block has no check.
module ultrasonic_echo_ranger_core #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned GAP_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  uer_pkg::uer_in_t               req_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output uer_pkg::uer_out_t              res_data,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import uer_pkg::*;

  localparam int unsigned CMP_W  = (GAP_WIDTH > 24) ? GAP_WIDTH : 24;
  localparam int unsigned PLS_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int unsigned PROD_W = COUNT_WIDTH + 24;
  localparam int unsigned PEXT_W = (PROD_W > 36) ? PROD_W : 37;

  // Configuration registers
  logic [23:0] gap_ticks;
  logic [7:0]  trigger_ticks;
  logic [23:0] cm_scale;

  // Input register
  logic    s1_valid;
  uer_in_t s1_data;
  logic    s1_adv;

  // Tick state
  phase_t                 phase, phase_next;
  logic [GAP_WIDTH-1:0]   gap_count, gap_count_next;
  logic [7:0]             trig_count, trig_count_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic                   echo_prev;
  logic                   object_flag, object_flag_next;
  logic                   new_flag, new_flag_next;
  logic [19:0]            distance_reg, distance_reg_next;
  logic [15:0]            pulse_reg, pulse_reg_next;

  // Tick events
  logic                   active, rise, fall, wrap, ends;
  logic [GAP_WIDTH-1:0]   gap_inc;
  logic                   gap_done;
  logic [7:0]             trig_inc;
  logic                   trig_done;
  logic [PROD_W-1:0]      prod;
  logic [PEXT_W-1:0]      prod_ext;
  logic [19:0]            dist_sat;
  logic [PLS_W-1:0]       pulse_wide;
  logic [15:0]            pulse_sat;

  // Handshake: the input register advances when the result register is free
  assign s1_adv    = s1_valid && (!res_valid || res_ready);
  assign req_ready = !s1_valid || s1_adv;

  // Capture configuration writes; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks     <= GAP_TICKS_RST;
      trigger_ticks <= TRIGGER_TICKS_RST;
      cm_scale      <= CM_SCALE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GAP_TICKS) begin
        gap_ticks <= cfg_wdata;
      end
      if (cfg_index == CFG_TRIGGER_TICKS) begin
        trigger_ticks <= cfg_wdata[7:0];
      end
      if (cfg_index == CFG_CM_SCALE) begin
        cm_scale <= cfg_wdata;
      end
    end
  end

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_data <= req_data;
    end
  end

  // Decode tick events
  assign active = (phase == PH_TRIG) || (phase == PH_MEAS);
  assign rise   = s1_data.echo_level && !echo_prev;
  assign fall   = !s1_data.echo_level && echo_prev;
  assign wrap   = !rise && !fall && (tick_count == {COUNT_WIDTH{1'b1}});
  assign ends   = fall || wrap;

  assign gap_inc  = (gap_count == {GAP_WIDTH{1'b1}}) ? gap_count
                                                     : gap_count + GAP_WIDTH'(1);
  assign gap_done = (CMP_W'(gap_inc) >= CMP_W'(gap_ticks))
                    || (gap_inc == {GAP_WIDTH{1'b1}});

  assign trig_inc  = (trig_count == TRIG_MAX) ? trig_count : trig_count + 8'd1;
  assign trig_done = trig_inc >= trigger_ticks;

  // Convert the tick count to distance, saturated to 20 bits
  assign prod       = PROD_W'(tick_count) * PROD_W'(cm_scale);
  assign prod_ext   = PEXT_W'(prod);
  assign dist_sat   = (|prod_ext[PEXT_W-1:36]) ? DIST_MAX : prod_ext[35:16];
  assign pulse_wide = PLS_W'(tick_count);
  assign pulse_sat  = (pulse_wide > PLS_W'(PULSE_MAX)) ? PULSE_MAX : pulse_wide[15:0];

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_TRIG: begin
        if (ends) begin
          phase_next = PH_GAP;
        end else if (trig_done) begin
          phase_next = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (ends) begin
          phase_next = PH_GAP;
        end
      end
      default: begin
        if (gap_done) begin
          phase_next = PH_TRIG;
        end
      end
    endcase
  end

  // Next counters, flags and latched results
  always_comb begin
    gap_count_next    = gap_count;
    trig_count_next   = trig_count;
    tick_count_next   = tick_count;
    object_flag_next  = object_flag;
    new_flag_next     = new_flag && !s1_data.read_clear;
    distance_reg_next = distance_reg;
    pulse_reg_next    = pulse_reg;
    if (active) begin
      if (phase == PH_TRIG) begin
        trig_count_next = trig_inc;
      end
      if (rise) begin
        tick_count_next = '0;
      end else if (fall) begin
        distance_reg_next = dist_sat;
        pulse_reg_next    = pulse_sat;
        object_flag_next  = 1'b1;
        new_flag_next     = 1'b1;
      end else if (wrap) begin
        tick_count_next  = '0;
        object_flag_next = 1'b0;
        new_flag_next    = 1'b1;
      end else begin
        tick_count_next = tick_count + COUNT_WIDTH'(1);
      end
    end else if (gap_done) begin
      gap_count_next   = '0;
      trig_count_next  = '0;
      tick_count_next  = '0;
      object_flag_next = 1'b0;
      new_flag_next    = 1'b0;
    end else begin
      gap_count_next = gap_inc;
    end
  end

  // Advance the tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_GAP;
      gap_count    <= '0;
      trig_count   <= '0;
      tick_count   <= '0;
      echo_prev    <= 1'b0;
      object_flag  <= 1'b0;
      new_flag     <= 1'b0;
      distance_reg <= '0;
      pulse_reg    <= '0;
    end else if (s1_adv) begin
      phase        <= phase_next;
      gap_count    <= gap_count_next;
      trig_count   <= trig_count_next;
      tick_count   <= tick_count_next;
      echo_prev    <= s1_data.echo_level;
      object_flag  <= object_flag_next;
      new_flag     <= new_flag_next;
      distance_reg <= distance_reg_next;
      pulse_reg    <= pulse_reg_next;
    end
  end

  // Load the result register; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_data.trigger_out  <= (phase_next == PH_TRIG);
      res_data.busy_res     <= (phase_next == PH_TRIG) || (phase_next == PH_MEAS);
      res_data.object_found <= object_flag_next;
      res_data.fresh        <= new_flag_next;
      res_data.distance_q8  <= distance_reg_next;
      res_data.pulse_ticks  <= pulse_reg_next;
    end
  end

`ifndef NO_ASSERTIONS
  // An echo end reports a found object and leaves the block idle
  a_fall_reports: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && active && fall) |=>
      (res_valid && res_data.object_found && res_data.fresh && !res_data.busy_res))
    else $error("echo end did not report an object");

  // A measurement start clears the tick and gap counters
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !active && gap_done) |=>
      (gap_count == '0 && tick_count == '0 && trig_count == '0 && phase == PH_TRIG))
    else $error("measurement start left counters set");

  // Tick state moves only when a request advances
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> ($stable(phase) && $stable(tick_count) && $stable(gap_count)))
    else $error("tick state changed without a request");

  // The result register is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !s1_adv)
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== bench/testbench.sv =====
// Testbench: checks every tick result of the echo ranger core against a predictor.
`timescale 1ns / 1ps

module testbench;
  import uer_pkg::*;

  localparam logic [15:0] TICK_FULL    = 16'hFFFF;
  localparam logic [23:0] GAP_FULL     = 24'hFFFFFF;
  localparam logic [23:0] SCALE_FULL   = 24'hFFFFFF;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          RANDOM_TICKS = 1000;
  localparam int          REPORT_LIMIT = 100;

  // Predictor of the ranger state plus the queue of expected readings
  class ranger_scoreboard;
    logic [23:0] gap_ticks;
    logic [7:0]  trigger_ticks;
    logic [23:0] cm_scale;
    phase_t      phase;
    logic [23:0] gap_count;
    logic [7:0]  trig_count;
    logic [15:0] tick_count;
    logic        echo_prev;
    logic        object_flag;
    logic        new_flag;
    logic [19:0] distance_reg;
    logic [15:0] pulse_reg;
    uer_out_t    expected_readings[$];
    int          errors = 0;

    function void reset_model();
      gap_ticks     = GAP_TICKS_RST;
      trigger_ticks = TRIGGER_TICKS_RST;
      cm_scale      = CM_SCALE_RST;
      phase         = PH_GAP;
      gap_count     = '0;
      trig_count    = '0;
      tick_count    = '0;
      echo_prev     = 1'b0;
      object_flag   = 1'b0;
      new_flag      = 1'b0;
      distance_reg  = '0;
      pulse_reg     = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_GAP_TICKS:     gap_ticks = value;
        CFG_TRIGGER_TICKS: trigger_ticks = value[7:0];
        CFG_CM_SCALE:      cm_scale = value;
        default: ;
      endcase
    endfunction

    // Advance the model by one tick and queue the reading it shows
    function void advance_tick(uer_in_t t);
      logic        rise;
      logic        fall;
      logic [24:0] g;
      logic [39:0] prod;
      uer_out_t    r;
      if (t.read_clear) new_flag = 1'b0;
      if (phase == PH_TRIG || phase == PH_MEAS) begin
        // a zero trigger length still gives one trigger tick
        if (phase == PH_TRIG) begin
          if (trig_count < TRIG_MAX) trig_count++;
          if (trig_count >= trigger_ticks) phase = PH_MEAS;
        end
        rise = t.echo_level && !echo_prev;
        fall = !t.echo_level && echo_prev;
        if (rise) begin
          tick_count = '0;
        end else if (fall) begin
          // latch the pulse and convert, saturating the distance
          prod = 40'(tick_count) * 40'(cm_scale);
          if (prod[39:16] > {4'd0, DIST_MAX}) distance_reg = DIST_MAX;
          else distance_reg = prod[35:16];
          pulse_reg   = tick_count;
          object_flag = 1'b1;
          new_flag    = 1'b1;
          phase       = PH_GAP;
        end else if (tick_count >= TICK_FULL) begin
          // counter wrap ends the measurement with no object
          tick_count  = '0;
          object_flag = 1'b0;
          new_flag    = 1'b1;
          phase       = PH_GAP;
        end else begin
          tick_count++;
        end
      end else begin
        // idle gap, saturating count; a zero gap acts as one tick
        g = {1'b0, gap_count} + 25'd1;
        if (g > {1'b0, GAP_FULL}) g = {1'b0, GAP_FULL};
        gap_count = g[23:0];
        if (g >= {1'b0, gap_ticks} || g >= {1'b0, GAP_FULL}) begin
          new_flag    = 1'b0;
          object_flag = 1'b0;
          tick_count  = '0;
          trig_count  = '0;
          gap_count   = '0;
          phase       = PH_TRIG;
        end
      end
      echo_prev = t.echo_level;

      r.trigger_out  = (phase == PH_TRIG);
      r.busy_res     = (phase == PH_TRIG) || (phase == PH_MEAS);
      r.object_found = object_flag;
      r.fresh        = new_flag;
      r.distance_q8  = distance_reg;
      r.pulse_ticks  = pulse_reg;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string field, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Check one reading against the oldest expectation
    function void check_reading(uer_out_t got);
      uer_out_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: reading with none expected: expected none, actual %h", $time, got);
      end else begin
        want = expected_readings.pop_front();
        compare_field("trigger_out", 20'(want.trigger_out), 20'(got.trigger_out));
        compare_field("busy_res", 20'(want.busy_res), 20'(got.busy_res));
        compare_field("object_found", 20'(want.object_found), 20'(got.object_found));
        compare_field("fresh", 20'(want.fresh), 20'(got.fresh));
        compare_field("distance_q8", want.distance_q8, got.distance_q8);
        compare_field("pulse_ticks", 20'(want.pulse_ticks), 20'(got.pulse_ticks));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  uer_in_t               req_data;
  logic                  res_valid;
  logic                  res_ready;
  uer_out_t              res_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ranger_scoreboard sb;
  bit               idle_on;
  int               quiet_cycles = 0;

  ultrasonic_echo_ranger_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both handshakes with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.advance_tick(req_data);
      if (res_valid && res_ready) sb.check_reading(res_data);
      if ((req_valid && req_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the result side in random bursts
  initial begin : result_stall
    int hold;
    hold = 0;
    res_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) res_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 9);
        res_ready <= 1'b0;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Send one tick request, with an optional idle burst ahead of it
  task automatic send_tick(input logic echo, input logic rd);
    uer_in_t item;
    item.echo_level = echo;
    item.read_clear = rd;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // Send an echo pulse framed by low ticks, with random reads
  task automatic send_echo_pulse(input int lead, input int width, input int tail);
    repeat (lead) send_tick(1'b0, $urandom_range(0, 4) == 0);
    repeat (width) send_tick(1'b1, $urandom_range(0, 4) == 0);
    repeat (tail) send_tick(1'b0, $urandom_range(0, 4) == 0);
  endtask

  // Drop valid and hold until every expected reading has arrived
  task automatic finish_phase();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_readings.size() != 0) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic apply_settings(input logic [23:0] gap, input logic [7:0] trig,
                                input logic [23:0] scale);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAP_TICKS;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= CFG_TRIGGER_TICKS;
    cfg_wdata <= {16'd0, trig};
    @(posedge clk);
    cfg_index <= CFG_CM_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_GAP_TICKS, gap);
    sb.set_register(CFG_TRIGGER_TICKS, {16'd0, trig});
    sb.set_register(CFG_CM_SCALE, scale);
  endtask

  initial begin : stimulus
    int          random_ticks;
    int          phase_ticks;
    int          phase_len;
    int          pick;
    int          lead;
    int          width;
    int          tail;
    int          len;
    logic [23:0] gap_pick;
    logic [7:0]  trig_pick;
    logic [23:0] scale_pick;
    sb = new;
    sb.reset_model();
    idle_on = 1'b1;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_GAP_TICKS;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: the long gap keeps every reading at rest
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    finish_phase();

    // zero gap and zero trigger length act as one tick, zero scale
    apply_settings(24'd0, 8'd0, 24'd0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    // read lands on the tick that ends the measurement
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    finish_phase();

    // longest trigger and full scale
    apply_settings(24'd2, TRIG_MAX, SCALE_FULL);
    send_echo_pulse(3, 300, 3);
    send_echo_pulse(1, 60, 2);
    finish_phase();

    // random phases, each with fresh settings; no idling near the end
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      if (random_ticks > RANDOM_TICKS - 300) idle_on = 1'b0;
      pick = $urandom_range(0, 7);
      if (pick == 0) gap_pick = 24'($urandom_range(1, 400));
      else gap_pick = 24'($urandom_range(1, 10));
      pick = $urandom_range(0, 7);
      if (pick == 0) trig_pick = TRIG_MAX;
      else if (pick == 1) trig_pick = 8'($urandom_range(1, 255));
      else trig_pick = 8'($urandom_range(1, 12));
      pick = $urandom_range(0, 5);
      if (pick == 0) scale_pick = 24'd0;
      else if (pick == 1) scale_pick = SCALE_FULL;
      else if (pick == 2) scale_pick = CM_SCALE_RST;
      else scale_pick = 24'($urandom_range(0, 32'hFFFFFF));
      apply_settings(gap_pick, trig_pick, scale_pick);

      phase_len   = $urandom_range(150, 300);
      phase_ticks = 0;
      while (phase_ticks < phase_len) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // noise on the echo line
          len = $urandom_range(1, 20);
          repeat (len) send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
          phase_ticks += len;
        end else begin
          lead = $urandom_range(0, 12);
          if ($urandom_range(0, 9) == 0) width = $urandom_range(61, 600);
          else width = $urandom_range(1, 60);
          tail = $urandom_range(1, 12);
          send_echo_pulse(lead, width, tail);
          phase_ticks += lead + width + tail;
        end
      end
      finish_phase();
      random_ticks += phase_ticks;
    end

    // widest gap: no measurement starts
    apply_settings(GAP_FULL, TRIG_MAX, SCALE_FULL);
    repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    finish_phase();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
